/* rtl/lkst_pkg.sv */
// shared types and constants for the lru keyed session table
`default_nettype none
package lkst_pkg;

	localparam int IN_KEY_BITS     = 48;
	localparam int IN_HANDLE_BITS  = 16;
	localparam int OUT_HANDLE_BITS = 16;
	localparam int STAMP_BITS      = 32;
	localparam int LIMIT_BITS      = 9;
	localparam int APB_DATA_BITS   = 32;
	localparam int APB_ADDR_BITS   = 3;
	localparam int REG_IDX_BITS    = APB_ADDR_BITS - 2;

	localparam logic [LIMIT_BITS-1:0]   LIMIT_RESET     = 9'd256;
	localparam logic [REG_IDX_BITS-1:0] REG_ENTRY_LIMIT = 1'b0;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_GET = 2'd1,
		CMD_DEL = 2'd2,
		CMD_USE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_DUPLICATE = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

endpackage
`default_nettype wire

/* rtl/lru_keyed_session_table.sv */
// lru keyed session table: scanned entry memory with recency stamps and an apb limit register
//
//  channel  | direction | handshake              | contents
//  s_*      | in        | s_tvalid / s_tready    | request: command, key, handle
//  m_*      | out       | m_tvalid / m_tready    | result: status, result_handle, evict info
//  apb      | in/out    | psel, penable, pready  | entry_limit at byte address 0
//
// every request takes a full pass over the entry memory, one slot a cycle through its read
// port, and an add that exceeds the limit needs a second pass for the oldest entry.
// after reset a clearing pass marks every slot free; s_tready is low.
// a result waits in the output register; the next request is taken meanwhile, but the
// following result waits until the previous one has been taken.
`default_nettype none
module lru_keyed_session_table #(
	parameter int TABLE_DEPTH = 512,
	parameter int KEY_BITS    = 48,
	parameter int HANDLE_BITS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// key [47:0], handle [63:48]
	input  wire logic [63:0]                          s_tdata,
	// command [1:0]
	input  wire logic [1:0]                           s_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// result_handle [15:0], evict_handle [31:16]
	output logic [31:0]                               m_tdata,
	// status [1:0], evict_valid [2]
	output logic [2:0]                                m_tuser,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [lkst_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  wire logic [lkst_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [lkst_pkg::APB_DATA_BITS-1:0]        prdata,
	output logic                                      pready
);

	localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int CMPW = ((CW > lkst_pkg::LIMIT_BITS) ? CW : lkst_pkg::LIMIT_BITS) + 1;
	localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_SCAN   = 6'b000100,
		S_DECIDE = 6'b001000,
		S_OLDEST = 6'b010000,
		S_RESULT = 6'b100000
	} state_t;

	typedef struct packed {
		logic                                valid;
		logic [KEY_BITS-1:0]                 key;
		logic [HANDLE_BITS-1:0]              hdl;
		logic [lkst_pkg::STAMP_BITS-1:0]     stamp;
	} entry_t;

	entry_t mem [TABLE_DEPTH];
	entry_t rd_s1;
	entry_t wr_data;
	logic            wr_en;
	logic [IW-1:0]   wr_addr;

	state_t                           state_q;
	logic [IW-1:0]                    idx_q;
	logic                             scan_on_q;
	logic                             v_s1;
	logic [IW-1:0]                    idx_s1;
	lkst_pkg::cmd_t                   cmd_q;
	logic [KEY_BITS-1:0]              key_q;
	logic [HANDLE_BITS-1:0]           hdl_q;
	logic                             key_hit_q, hdl_hit_q, free_hit_q, old_hit_q;
	logic [IW-1:0]                    key_slot_q, hdl_slot_q, free_slot_q;
	logic [HANDLE_BITS-1:0]           key_hdl_q, old_hdl_q;
	logic [lkst_pkg::STAMP_BITS-1:0]  old_age_q, stamp_q, age;
	logic [CW-1:0]                    live_q;
	logic [lkst_pkg::LIMIT_BITS-1:0]  limit_q;
	lkst_pkg::status_t                res_status_q, dec_status;
	logic [lkst_pkg::OUT_HANDLE_BITS-1:0] res_hdl_q;
	logic                             m_tvalid_q;
	logic [31:0]                      m_tdata_q;
	logic [2:0]                       m_tuser_q;

	logic accept, scan_done, go_oldest, out_load, cfg_wr;
	logic take_key, take_hdl, take_free, take_old;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign scan_done = v_s1 && (idx_s1 == LAST);
	assign out_load  = (state_q == S_RESULT) && (!m_tvalid_q || m_tready);
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready
		&& (paddr[lkst_pkg::APB_ADDR_BITS-1:2] == lkst_pkg::REG_ENTRY_LIMIT);
	assign prdata    = (paddr[lkst_pkg::APB_ADDR_BITS-1:2] == lkst_pkg::REG_ENTRY_LIMIT)
		? lkst_pkg::APB_DATA_BITS'(limit_q) : '0;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// shared compare unit on the registered read word
	assign age       = stamp_q - rd_s1.stamp;
	assign take_key  = (state_q == S_SCAN) && v_s1 && rd_s1.valid && !key_hit_q
		&& (rd_s1.key == key_q);
	assign take_hdl  = (state_q == S_SCAN) && v_s1 && rd_s1.valid && !hdl_hit_q
		&& (rd_s1.hdl == hdl_q);
	assign take_free = (state_q == S_SCAN) && v_s1 && !rd_s1.valid && !free_hit_q;
	assign take_old  = (state_q == S_OLDEST) && v_s1 && rd_s1.valid
		&& (!old_hit_q || (age > old_age_q));

	assign go_oldest = (state_q == S_DECIDE) && (cmd_q == lkst_pkg::CMD_ADD) && wr_en
		&& ((CMPW'(live_q) + CMPW'(1)) > CMPW'(limit_q));

	always_comb begin
		wr_en         = 1'b0;
		wr_addr       = idx_q;
		wr_data.valid = 1'b0;
		wr_data.key   = key_q;
		wr_data.hdl   = hdl_q;
		wr_data.stamp = stamp_q;
		dec_status    = lkst_pkg::ST_OK;
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_DECIDE: begin
				case (cmd_q)
					lkst_pkg::CMD_ADD: begin
						if (key_hit_q) begin
							dec_status = lkst_pkg::ST_DUPLICATE;
						end else if (!free_hit_q) begin
							dec_status = lkst_pkg::ST_FULL;
						end else begin
							wr_en         = 1'b1;
							wr_addr       = free_slot_q;
							wr_data.valid = 1'b1;
						end
					end
					lkst_pkg::CMD_GET: begin
						if (!key_hit_q) begin
							dec_status = lkst_pkg::ST_NOT_FOUND;
						end else begin
							wr_en         = 1'b1;
							wr_addr       = key_slot_q;
							wr_data.valid = 1'b1;
							wr_data.hdl   = key_hdl_q;
						end
					end
					lkst_pkg::CMD_DEL: begin
						if (!hdl_hit_q) begin
							dec_status = lkst_pkg::ST_NOT_FOUND;
						end else begin
							wr_en   = 1'b1;
							wr_addr = hdl_slot_q;
						end
					end
					lkst_pkg::CMD_USE: begin
						if (!hdl_hit_q) begin
							dec_status = lkst_pkg::ST_NOT_FOUND;
						end else if (key_hit_q && (key_slot_q != hdl_slot_q)) begin
							dec_status = lkst_pkg::ST_DUPLICATE;
						end else begin
							wr_en         = 1'b1;
							wr_addr       = hdl_slot_q;
							wr_data.valid = 1'b1;
						end
					end
					default: begin
						dec_status = lkst_pkg::ST_OK;
					end
				endcase
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_s1 <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			idx_q      <= '0;
			scan_on_q  <= 1'b0;
			v_s1       <= 1'b0;
			key_hit_q  <= 1'b0;
			hdl_hit_q  <= 1'b0;
			free_hit_q <= 1'b0;
			old_hit_q  <= 1'b0;
			stamp_q    <= '0;
			live_q     <= '0;
			limit_q    <= lkst_pkg::LIMIT_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			v_s1 <= scan_on_q;
			if (cfg_wr) begin
				limit_q <= pwdata[lkst_pkg::LIMIT_BITS-1:0];
			end
			if (take_key) begin
				key_hit_q <= 1'b1;
			end
			if (take_hdl) begin
				hdl_hit_q <= 1'b1;
			end
			if (take_free) begin
				free_hit_q <= 1'b1;
			end
			if (take_old) begin
				old_hit_q <= 1'b1;
			end
			if (scan_on_q) begin
				if (idx_q == LAST) begin
					scan_on_q <= 1'b0;
				end else begin
					idx_q <= idx_q + IW'(1);
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (idx_q == LAST) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						idx_q      <= '0;
						scan_on_q  <= 1'b1;
						key_hit_q  <= 1'b0;
						hdl_hit_q  <= 1'b0;
						free_hit_q <= 1'b0;
						state_q    <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					old_hit_q <= 1'b0;
					if (wr_en && (cmd_q != lkst_pkg::CMD_DEL)) begin
						stamp_q <= stamp_q + lkst_pkg::STAMP_BITS'(1);
					end
					if (wr_en && (cmd_q == lkst_pkg::CMD_ADD)) begin
						live_q <= live_q + CW'(1);
					end
					if (wr_en && (cmd_q == lkst_pkg::CMD_DEL) && (live_q != '0)) begin
						live_q <= live_q - CW'(1);
					end
					if (go_oldest) begin
						idx_q     <= '0;
						scan_on_q <= 1'b1;
						state_q   <= S_OLDEST;
					end else begin
						state_q <= S_RESULT;
					end
				end
				S_OLDEST: begin
					if (scan_done) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request and scan payload
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (accept) begin
			cmd_q <= lkst_pkg::cmd_t'(s_tuser);
			key_q <= KEY_BITS'(s_tdata[lkst_pkg::IN_KEY_BITS-1:0]);
			hdl_q <= HANDLE_BITS'(s_tdata[lkst_pkg::IN_KEY_BITS +: lkst_pkg::IN_HANDLE_BITS]);
		end
		if (take_key) begin
			key_slot_q <= idx_s1;
			key_hdl_q  <= rd_s1.hdl;
		end
		if (take_hdl) begin
			hdl_slot_q <= idx_s1;
		end
		if (take_free) begin
			free_slot_q <= idx_s1;
		end
		if (take_old) begin
			old_age_q <= age;
			old_hdl_q <= rd_s1.hdl;
		end
		if (state_q == S_DECIDE) begin
			res_status_q <= dec_status;
			res_hdl_q    <= ((cmd_q == lkst_pkg::CMD_GET) && key_hit_q)
				? lkst_pkg::OUT_HANDLE_BITS'(key_hdl_q) : '0;
		end
		if (out_load) begin
			m_tdata_q <= {(old_hit_q ? lkst_pkg::OUT_HANDLE_BITS'(old_hdl_q)
				: lkst_pkg::OUT_HANDLE_BITS'(0)), res_hdl_q};
			m_tuser_q <= {old_hit_q, res_status_q};
		end
	end

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(live_q) <= CMPW'(TABLE_DEPTH))
		else $error("live count above table depth");

	a_stamp_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) && wr_en && (cmd_q != lkst_pkg::CMD_DEL)
		|=> stamp_q == $past(stamp_q) + lkst_pkg::STAMP_BITS'(1))
		else $error("recency stamp not advanced on touch");

	a_scan_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == S_SCAN) || (state_q == S_OLDEST))
		else $error("read data outside a scan");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid && (state_q == S_IDLE))
		else $error("result not presented");

endmodule
`default_nettype wire

/* test/lkst_reply_checker.sv */
// reply checker: predicts every session table reply and compares it with the result channel
`default_nettype none
module lkst_reply_checker
	import lkst_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	input  wire logic                     s_tready,
	// key [47:0], handle [63:48]
	input  wire logic [63:0]              s_tdata,
	// command [1:0]
	input  wire logic [1:0]               s_tuser,
	input  wire logic                     m_tvalid,
	input  wire logic                     m_tready,
	// result_handle [15:0], evict_handle [31:16]
	input  wire logic [31:0]              m_tdata,
	// status [1:0], evict_valid [2]
	input  wire logic [2:0]               m_tuser,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_ADDR_BITS-1:0] paddr,
	input  wire logic [APB_DATA_BITS-1:0] pwdata,
	input  wire logic [APB_DATA_BITS-1:0] prdata,
	input  wire logic                     pready,
	output int                            mismatches,
	output int                            replies_left
);

	localparam int SLOTS = 512;

	typedef struct packed {
		status_t                    status;
		logic [OUT_HANDLE_BITS-1:0] found_handle;
		logic                       evict;
		logic [OUT_HANDLE_BITS-1:0] evict_handle;
	} reply_t;

	logic [IN_KEY_BITS-1:0]    slot_key    [SLOTS];
	logic [IN_HANDLE_BITS-1:0] slot_handle [SLOTS];
	logic [STAMP_BITS-1:0]     slot_stamp  [SLOTS];
	bit                        slot_live   [SLOTS];
	logic [STAMP_BITS-1:0]     stamp_now;
	int                        live_total;
	logic [LIMIT_BITS-1:0]     limit;
	reply_t                    replies_due [$];

	function automatic int slot_of_key(logic [IN_KEY_BITS-1:0] k);
		for (int i = 0; i < SLOTS; i++)
			if (slot_live[i] && slot_key[i] == k) return i;
		return -1;
	endfunction

	function automatic int slot_of_handle(logic [IN_HANDLE_BITS-1:0] h);
		for (int i = 0; i < SLOTS; i++)
			if (slot_live[i] && slot_handle[i] == h) return i;
		return -1;
	endfunction

	function automatic void make_newest(int s);
		slot_stamp[s] = stamp_now;
		stamp_now = stamp_now + 1'b1;
	endfunction

	function automatic reply_t apply_request(cmd_t cmd, logic [IN_KEY_BITS-1:0] k,
			logic [IN_HANDLE_BITS-1:0] h);
		reply_t                r;
		int                    s;
		int                    other;
		logic [STAMP_BITS-1:0] age;
		logic [STAMP_BITS-1:0] oldest_age;
		r = '0;
		r.status = ST_OK;
		case (cmd)
			CMD_ADD: begin
				if (slot_of_key(k) >= 0) begin
					r.status = ST_DUPLICATE;
				end else begin
					s = -1;
					for (int i = SLOTS - 1; i >= 0; i--)
						if (!slot_live[i]) s = i;
					if (s < 0) begin
						r.status = ST_FULL;
					end else begin
						slot_live[s] = 1'b1;
						slot_key[s] = k;
						slot_handle[s] = h;
						make_newest(s);
						live_total++;
						if (live_total > int'(limit)) begin
							other = -1;
							oldest_age = '0;
							for (int i = 0; i < SLOTS; i++) begin
								if (slot_live[i]) begin
									age = stamp_now - slot_stamp[i];
									if (other < 0 || age > oldest_age) begin
										other = i;
										oldest_age = age;
									end
								end
							end
							r.evict = 1'b1;
							r.evict_handle = slot_handle[other];
						end
					end
				end
			end
			CMD_GET: begin
				s = slot_of_key(k);
				if (s < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					make_newest(s);
					r.found_handle = slot_handle[s];
				end
			end
			CMD_DEL: begin
				s = slot_of_handle(h);
				if (s < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					slot_live[s] = 1'b0;
					if (live_total > 0) live_total--;
				end
			end
			default: begin
				s = slot_of_handle(h);
				if (s < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					other = slot_of_key(k);
					if (other >= 0 && other != s) begin
						r.status = ST_DUPLICATE;
					end else begin
						slot_key[s] = k;
						make_newest(s);
					end
				end
			end
		endcase
		return r;
	endfunction

	task automatic log_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("%s", msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		reply_t got;
		reply_t want;
		if (!arst_n) begin
			foreach (slot_live[i]) slot_live[i] = 1'b0;
			stamp_now = '0;
			live_total = 0;
			limit = LIMIT_RESET;
			replies_due.delete();
			mismatches = 0;
			replies_left = 0;
		end else begin
			if (psel && penable && pready && paddr[APB_ADDR_BITS-1:2] == REG_ENTRY_LIMIT) begin
				if (pwrite) begin
					limit = pwdata[LIMIT_BITS-1:0];
				end else if (prdata !== APB_DATA_BITS'(limit)) begin
					log_mismatch($sformatf("limit read: want %0d got %h", limit, prdata));
				end
			end
			if (s_tvalid && s_tready)
				replies_due.push_back(apply_request(cmd_t'(s_tuser), s_tdata[47:0],
					s_tdata[63:48]));
			if (m_tvalid && m_tready) begin
				got = reply_t'({m_tuser[1:0], m_tdata[15:0], m_tuser[2], m_tdata[31:16]});
				if (replies_due.size() == 0) begin
					log_mismatch($sformatf("reply with no request waiting: %h", got));
				end else begin
					want = replies_due.pop_front();
					if (got !== want)
						log_mismatch($sformatf(
							"reply: want st %0d h %h ev %b %h, got st %0d h %h ev %b %h",
							want.status, want.found_handle, want.evict, want.evict_handle,
							got.status, got.found_handle, got.evict, got.evict_handle));
				end
			end
			replies_left = replies_due.size();
		end
	end

endmodule
`default_nettype wire

/* test/tb_lru_keyed_session_table.sv */
// testbench top: drives requests and limit writes into the session table and gives the verdict
`default_nettype none
module tb_lru_keyed_session_table;
	import lkst_pkg::*;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [63:0]              s_tdata;
	logic [1:0]               s_tuser;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [31:0]              m_tdata;
	logic [2:0]               m_tuser;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	int                        sent_count = 0;
	int                        results_seen = 0;
	int                        mismatches;
	int                        replies_left;
	bit                        honor_evict = 1'b0;
	logic [IN_KEY_BITS-1:0]    pool_keys    [$];
	logic [IN_HANDLE_BITS-1:0] pool_handles [$];
	logic [IN_HANDLE_BITS-1:0] evict_todo   [$];

	lru_keyed_session_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	lkst_reply_checker table_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.mismatches   (mismatches),
		.replies_left (replies_left)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#300_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 20);
		return $urandom_range(100, 700);
	endfunction

	function automatic logic [IN_KEY_BITS-1:0] fresh_key();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[IN_KEY_BITS-1:0];
	endfunction

	function automatic int recent_index();
		int n;
		n = pool_keys.size();
		if ($urandom_range(0, 3) != 0)
			return n - 1 - int'($urandom_range(0, (n > 12) ? 11 : n - 1));
		return $urandom_range(0, n - 1);
	endfunction

	function automatic void remember(logic [IN_KEY_BITS-1:0] k, logic [IN_HANDLE_BITS-1:0] h);
		pool_keys.push_back(k);
		pool_handles.push_back(h);
		if (pool_keys.size() > 64) begin
			pool_keys.delete(0);
			pool_handles.delete(0);
		end
	endfunction

	// results taken by the receiver; while honor_evict is set, evictions are handed back as delete requests
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (honor_evict && m_tuser[2]) evict_todo.push_back(m_tdata[31:16]);
		end
	end

	initial begin : receiver
		int stall;
		bit pressed;
		stall = 0;
		pressed = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!pressed && results_seen >= 300) begin
				pressed = 1'b1;
				stall = 3000;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				if ((results_seen / 40) % 4 != 1 && $urandom_range(0, 7) == 0)
					stall = gap_len();
			end
		end
	end

	task automatic send_request(input cmd_t c, input logic [IN_KEY_BITS-1:0] k,
			input logic [IN_HANDLE_BITS-1:0] h);
		int gap;
		gap = ((sent_count / 40) % 4 == 3) ? 0 : gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= {h, k};
		do @(posedge clk); while (!s_tready);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic apb_cycle(input logic wr, input logic [LIMIT_BITS-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {REG_ENTRY_LIMIT, 2'b00};
		pwdata  <= APB_DATA_BITS'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_limit(input logic [LIMIT_BITS-1:0] value);
		s_tvalid <= 1'b0;
		while (results_seen != sent_count) @(negedge clk);
		apb_cycle(1'b1, value);
		apb_cycle(1'b0, value);
	endtask

	task automatic random_requests(input int count);
		int                        pick;
		int                        i;
		int                        r;
		logic [IN_KEY_BITS-1:0]    k;
		logic [IN_HANDLE_BITS-1:0] h;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (honor_evict && evict_todo.size() > 0) begin
				send_request(CMD_DEL, fresh_key(), evict_todo.pop_front());
			end else if (pick < 35 || pool_keys.size() == 0) begin
				k = fresh_key();
				if ($urandom_range(0, 9) == 0 && pool_handles.size() > 0)
					h = pool_handles[$urandom_range(0, pool_handles.size() - 1)];
				else
					h = 16'($urandom);
				send_request(CMD_ADD, k, h);
				remember(k, h);
			end else if (pick < 65) begin
				i = recent_index();
				k = ($urandom_range(0, 4) == 0) ? fresh_key() : pool_keys[i];
				send_request(CMD_GET, k, 16'($urandom));
			end else if (pick < 80) begin
				i = recent_index();
				if ($urandom_range(0, 4) == 0) begin
					send_request(CMD_DEL, fresh_key(), 16'($urandom));
				end else begin
					send_request(CMD_DEL, fresh_key(), pool_handles[i]);
					pool_keys.delete(i);
					pool_handles.delete(i);
				end
			end else if (pick < 95) begin
				i = recent_index();
				r = $urandom_range(0, 19);
				if (r < 12) k = fresh_key();
				else if (r < 17) k = pool_keys[$urandom_range(0, pool_keys.size() - 1)];
				else k = pool_keys[i];
				send_request(CMD_USE, k, pool_handles[i]);
				if (r < 12) pool_keys[i] = k;
			end else begin
				send_request(cmd_t'($urandom_range(0, 3)), fresh_key(), 16'($urandom));
			end
		end
	endtask

	initial begin : stimulus
		int                     pick;
		logic [IN_KEY_BITS-1:0] k;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = CMD_ADD;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		apb_cycle(1'b0, '0);

		// zero limit: the first add reports itself
		set_limit(9'd0);
		send_request(CMD_ADD, '0, '0);
		send_request(CMD_ADD, '1, '1);

		set_limit(9'd511);
		send_request(CMD_ADD, '0, 16'h0001);
		send_request(CMD_GET, '0, '0);
		send_request(CMD_GET, 48'h1234_5678_9abc, '0);
		send_request(CMD_USE, 48'h8000_0000_0001, '1);
		send_request(CMD_USE, '0, '1);
		send_request(CMD_USE, '0, '0);
		send_request(CMD_USE, 48'h0000_0000_7777, 16'h7777);
		// repeated handles act on the lowest slot
		send_request(CMD_ADD, 48'h5555_5555_5555, 16'h1234);
		send_request(CMD_ADD, 48'haaaa_aaaa_aaaa, 16'h1234);
		send_request(CMD_USE, 48'h0f0f_0f0f_0f0f, 16'h1234);
		send_request(CMD_DEL, '0, 16'h1234);
		send_request(CMD_GET, 48'haaaa_aaaa_aaaa, '0);
		send_request(CMD_GET, 48'h0f0f_0f0f_0f0f, '0);
		send_request(CMD_DEL, '1, 16'h1234);
		send_request(CMD_DEL, '1, 16'h1234);
		send_request(CMD_DEL, '0, '0);
		send_request(CMD_DEL, '0, '1);
		send_request(CMD_GET, 48'h8000_0000_0001, '1);

		honor_evict = 1'b1;
		set_limit(9'd1);
		random_requests(120);
		set_limit(9'd8);
		random_requests(200);
		set_limit(9'($urandom_range(2, 300)));
		random_requests(150);
		set_limit(9'd256);
		random_requests(100);

		// fill every slot, then keep adding into full storage
		honor_evict = 1'b0;
		set_limit(9'd511);
		repeat (600) begin
			pick = $urandom_range(0, 99);
			if (pick < 92 || pool_keys.size() == 0) begin
				k = fresh_key();
				send_request(CMD_ADD, k, 16'($urandom));
				remember(k, s_tdata[63:48]);
			end else if (pick < 96) begin
				send_request(CMD_GET, pool_keys[recent_index()], 16'($urandom));
			end else begin
				send_request(CMD_ADD, pool_keys[recent_index()], 16'($urandom));
			end
		end

		s_tvalid <= 1'b0;
		while (results_seen != sent_count) @(negedge clk);
		repeat (1100) @(negedge clk);
		if (mismatches == 0 && replies_left == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire

/* lru_keyed_session_table.f */
rtl/lkst_pkg.sv
rtl/lru_keyed_session_table.sv
test/lkst_reply_checker.sv
test/tb_lru_keyed_session_table.sv
